### rtl/c_subset_lexer_defines.svh
// ----------------------------------------------------------------------------
// C subset lexer assertion macros
// Clocked assertion helpers shared by the lexer modules. They use the
// module's clock and reset ports and are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH
`ifndef SYNTH
`define CSL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CSL_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define CSL_ASSERT(label, prop, msg)
`define CSL_ASSERT_NEVER(label, expr, msg)
`endif
`endif

### rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// C subset lexer package
// Token kinds, scan modes, character codes, keyword table and result types.
// ----------------------------------------------------------------------------
package csl_pkg;

   localparam int MAX_LEXEME_DEF    = 63;
   localparam int POSITION_BITS_DEF = 20;
   localparam int LINE_BITS_DEF     = 16;

   localparam int WINDOW_BYTES = 6;
   localparam int WINDOW_W     = 8 * WINDOW_BYTES;
   localparam int KW_COUNT     = 6;
   localparam int COUNT_BITS   = 8;

   localparam int KIND_W  = 4;
   localparam int KW_W    = 3;
   localparam int CHAR_W  = 8;
   localparam int LINE_W  = 16;
   localparam int START_W = 20;
   localparam int LEN_W   = 6;

   localparam int TDATA_RAW_W = KW_W + CHAR_W + 1 + LINE_W + START_W + LEN_W + 1;
   localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      TK_KEYWORD   = 4'd0,
      TK_IDENT     = 4'd1,
      TK_NUMBER    = 4'd2,
      TK_OPERATOR  = 4'd3,
      TK_ASSIGN    = 4'd4,
      TK_SEMICOLON = 4'd5,
      TK_LPAREN    = 4'd6,
      TK_RPAREN    = 4'd7,
      TK_LBRACE    = 4'd8,
      TK_RBRACE    = 4'd9,
      TK_EOF       = 4'd10
   } csl_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_NUM  = 2'd2,
      MODE_REL  = 2'd3
   } csl_mode_type;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Keyword text, first character in the lowest byte, zero padded.
   localparam logic [WINDOW_W-1:0] KW_TEXT [KW_COUNT] = '{
      48'h00_00_00_74_6E_69,
      48'h00_74_61_6F_6C_66,
      48'h00_00_00_00_66_69,
      48'h00_00_65_73_6C_65,
      48'h6E_72_75_74_65_72,
      48'h00_65_6C_69_68_77
   };
   localparam logic [COUNT_BITS-1:0] KW_LEN [KW_COUNT] = '{
      8'd3, 8'd5, 8'd2, 8'd4, 8'd6, 8'd5
   };

   typedef struct packed {
      logic            hit;
      logic [KW_W-1:0] idx;
   } csl_kw_type;

   typedef struct packed {
      csl_kind_type       kind;
      logic [KW_W-1:0]    kw_idx;
      logic [CHAR_W-1:0]  op_char;
      logic               op_eq;
      logic [LINE_W-1:0]  line;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic               too_long;
      logic               last;
   } csl_res_type;

   typedef struct packed {
      logic [1:0]  count;
      csl_res_type first;
      csl_res_type second;
   } csl_batch_type;

   function automatic logic csl_is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic csl_is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic csl_is_word(input logic [7:0] c);
      return csl_is_letter(c) || csl_is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic csl_is_rel(input logic [7:0] c);
      return c == CH_LT || c == CH_GT || c == CH_BANG || c == CH_EQ;
   endfunction

   function automatic csl_kw_type csl_kw_lookup(input logic [WINDOW_W-1:0] win,
                                                input logic [COUNT_BITS-1:0] cnt);
      csl_kw_type res;
      res = '0;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (win == KW_TEXT[i] && cnt == KW_LEN[i]) begin
            res.hit = 1'b1;
            res.idx = KW_W'(i);
         end
      end
      return res;
   endfunction

endpackage

### rtl/csl_scan_core.sv
// ----------------------------------------------------------------------------
// C subset lexer scan core
// Holds the scan state and turns one byte into up to two finished tokens.
// ----------------------------------------------------------------------------
module csl_scan_core
   import csl_pkg::*;
#(
   parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int LINE_BITS     = LINE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [7:0]    char_code,
   input  logic          end_of_text,
   output csl_batch_type batch
);

`include "c_subset_lexer_defines.svh"

   localparam int CW = $clog2(MAX_LEXEME + 1);

   csl_mode_type         mode_ff, mode_in;
   logic [7:0]           pend_ff, pend_in;
   logic [WINDOW_W-1:0]  win_ff, win_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 ovf_ff, ovf_in;

   csl_kw_type           kw;
   csl_res_type          flush_res, single_res, eof_res, rel_eq_res;
   logic                 has_flush, has_single;
   logic [WINDOW_W-1:0]  ext_win;
   logic [CW-1:0]        ext_count;
   logic                 ext_ovf;
   logic [POSITION_BITS-1:0] pos_next;

   always_comb begin
      kw = csl_kw_lookup(win_ff, COUNT_BITS'(count_ff));
      pos_next = pos_ff + POSITION_BITS'(1);

      ext_win   = win_ff;
      ext_count = count_ff;
      ext_ovf   = ovf_ff;
      if (int'(count_ff) < MAX_LEXEME) begin
         for (int i = 0; i < WINDOW_BYTES; i++) begin
            if (int'(count_ff) == i) begin
               ext_win[8*i +: 8] = char_code;
            end
         end
         ext_count = count_ff + CW'(1);
      end else begin
         ext_ovf = 1'b1;
      end

      flush_res       = '0;
      flush_res.line  = LINE_W'(line_ff);
      flush_res.start = START_W'(start_ff);
      has_flush       = 1'b1;
      unique case (mode_ff)
         MODE_WORD: begin
            flush_res.len = LEN_W'(count_ff);
            if (kw.hit && !ovf_ff) begin
               flush_res.kind   = TK_KEYWORD;
               flush_res.kw_idx = kw.idx;
            end else begin
               flush_res.kind     = TK_IDENT;
               flush_res.too_long = ovf_ff;
            end
         end
         MODE_NUM: begin
            flush_res.kind     = TK_NUMBER;
            flush_res.len      = LEN_W'(count_ff);
            flush_res.too_long = ovf_ff;
         end
         MODE_REL: begin
            flush_res.len = LEN_W'(1);
            if (pend_ff == CH_EQ) begin
               flush_res.kind = TK_ASSIGN;
            end else begin
               flush_res.kind    = TK_OPERATOR;
               flush_res.op_char = pend_ff;
            end
         end
         default: begin
            has_flush = 1'b0;
         end
      endcase

      single_res       = '0;
      single_res.line  = LINE_W'(line_ff);
      single_res.start = START_W'(pos_ff);
      single_res.len   = LEN_W'(1);
      has_single       = 1'b1;
      priority if (char_code == CH_PLUS || char_code == CH_MINUS ||
                   char_code == CH_STAR || char_code == CH_SLASH) begin
         single_res.kind    = TK_OPERATOR;
         single_res.op_char = char_code;
      end else if (char_code == CH_SEMI) begin
         single_res.kind = TK_SEMICOLON;
      end else if (char_code == CH_LPAREN) begin
         single_res.kind = TK_LPAREN;
      end else if (char_code == CH_RPAREN) begin
         single_res.kind = TK_RPAREN;
      end else if (char_code == CH_LBRACE) begin
         single_res.kind = TK_LBRACE;
      end else if (char_code == CH_RBRACE) begin
         single_res.kind = TK_RBRACE;
      end else begin
         has_single = 1'b0;
      end

      eof_res       = '0;
      eof_res.kind  = TK_EOF;
      eof_res.line  = LINE_W'(line_ff);
      eof_res.start = START_W'(pos_ff);

      rel_eq_res         = '0;
      rel_eq_res.kind    = TK_OPERATOR;
      rel_eq_res.op_char = pend_ff;
      rel_eq_res.op_eq   = 1'b1;
      rel_eq_res.line    = LINE_W'(line_ff);
      rel_eq_res.start   = START_W'(start_ff);
      rel_eq_res.len     = LEN_W'(2);

      mode_in  = mode_ff;
      pend_in  = pend_ff;
      win_in   = win_ff;
      count_in = count_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      ovf_in   = ovf_ff;
      batch    = '0;

      if (end_of_text) begin
         if (has_flush) begin
            batch.first  = flush_res;
            batch.second = eof_res;
            batch.count  = 2'd2;
         end else begin
            batch.first = eof_res;
            batch.count = 2'd1;
         end
         mode_in  = MODE_IDLE;
         pend_in  = '0;
         win_in   = '0;
         count_in = '0;
         start_in = '0;
         pos_in   = '0;
         line_in  = LINE_BITS'(1);
         ovf_in   = 1'b0;
      end else if ((mode_ff == MODE_WORD && csl_is_word(char_code)) ||
                   (mode_ff == MODE_NUM && csl_is_digit(char_code))) begin
         win_in   = ext_win;
         count_in = ext_count;
         ovf_in   = ext_ovf;
         pos_in   = pos_next;
      end else if (mode_ff == MODE_REL && char_code == CH_EQ) begin
         batch.first = rel_eq_res;
         batch.count = 2'd1;
         mode_in     = MODE_IDLE;
         pend_in     = '0;
         pos_in      = pos_next;
      end else begin
         mode_in = MODE_IDLE;
         if (mode_ff == MODE_REL) begin
            pend_in = '0;
         end
         priority if (char_code == CH_NL) begin
            if (line_ff != '1) begin
               line_in = line_ff + LINE_BITS'(1);
            end
         end else if (csl_is_letter(char_code) || char_code == CH_UNDER) begin
            mode_in  = MODE_WORD;
            win_in   = {{(WINDOW_W-8){1'b0}}, char_code};
            count_in = CW'(1);
            ovf_in   = 1'b0;
            start_in = pos_ff;
         end else if (csl_is_digit(char_code)) begin
            mode_in  = MODE_NUM;
            win_in   = {{(WINDOW_W-8){1'b0}}, char_code};
            count_in = CW'(1);
            ovf_in   = 1'b0;
            start_in = pos_ff;
         end else if (csl_is_rel(char_code)) begin
            mode_in  = MODE_REL;
            pend_in  = char_code;
            start_in = pos_ff;
         end else begin
            mode_in = MODE_IDLE;
         end
         if (has_flush) begin
            batch.first = flush_res;
            if (has_single) begin
               batch.second = single_res;
               batch.count  = 2'd2;
            end else begin
               batch.count = 2'd1;
            end
         end else if (has_single) begin
            batch.first = single_res;
            batch.count = 2'd1;
         end
         pos_in = pos_next;
      end

      if (batch.count == 2'd1) begin
         batch.first.last = 1'b1;
      end
      if (batch.count == 2'd2) begin
         batch.second.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= '0;
         win_ff   <= '0;
         count_ff <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= LINE_BITS'(1);
         ovf_ff   <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         win_ff   <= win_in;
         count_ff <= count_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         ovf_ff   <= ovf_in;
      end
   end

   `CSL_ASSERT(a_rel_pending, (mode_ff == MODE_REL) |-> (pend_ff == CH_LT || pend_ff == CH_GT || pend_ff == CH_BANG || pend_ff == CH_EQ), "pending relational byte is not a relational character")
   `CSL_ASSERT(a_ovf_count, ovf_ff |-> (int'(count_ff) == MAX_LEXEME), "length overflow without a saturated count")
   `CSL_ASSERT_NEVER(a_line_zero, line_ff == '0, "line counter reached zero")

endmodule

### rtl/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// C subset lexer
// Byte-serial tokenizer for a small C subset with a two-entry result queue.
// ----------------------------------------------------------------------------
// The req channel carries one source byte per transfer in req_tdata; a transfer
// with req_tlast high marks end of text, its byte is ignored, any pending token
// is flushed and an EOF token follows. The rsp channel carries one token per
// transfer: the kind in rsp_tuser, the other fields in rsp_tdata, and rsp_tlast
// on the final token caused by one input byte.
// The first token a byte yields is visible on rsp the cycle after the byte is
// taken. A byte that completes two tokens (a pending token plus a single
// character token or EOF) delivers them in order from the two queue entries.
// Throughput is one byte per cycle while each byte yields at most one token and
// rsp_tready stays high; a byte yielding two tokens holds req_tready low until
// its first token leaves; the queue drains one token per cycle while
// rsp_tready is high. When the receiver stalls, up to two tokens wait in the
// queue and req_tready stays low until the queue will be empty. Reset empties
// the queue; reset and EOF return the scanner to idle, position zero, line one.
// ----------------------------------------------------------------------------
module c_subset_lexer
   import csl_pkg::*;
#(
   parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int LINE_BITS     = LINE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // char_code
   input  logic               req_tlast,   // end_of_text
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // keyword_index, operator_char, operator_with_equal, line_number,
   // start_offset, lexeme_length, too_long, zero pad
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]  rsp_tuser,   // token_kind
   output logic               rsp_tlast    // last_of_run
);

`include "c_subset_lexer_defines.svh"

   csl_batch_type batch;
   logic          take, pop;
   logic [1:0]    cnt_ff, cnt_in;
   csl_res_type   head_ff, head_in;
   csl_res_type   tail_ff, tail_in;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign req_tready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign take       = req_tvalid && req_tready;

   csl_scan_core #(
      .MAX_LEXEME    (MAX_LEXEME),
      .POSITION_BITS (POSITION_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (req_tdata),
      .end_of_text (req_tlast),
      .batch       (batch)
   );

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      if (take) begin
         cnt_in  = batch.count;
         head_in = batch.first;
         tail_in = batch.second;
      end else if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         head_in = tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tdata = TDATA_W'({head_ff.too_long, head_ff.len, head_ff.start,
                                head_ff.line, head_ff.op_eq, head_ff.op_char,
                                head_ff.kw_idx});
   assign rsp_tuser = head_ff.kind;
   assign rsp_tlast = head_ff.last;

   `CSL_ASSERT(a_eof_queued, (take && req_tlast) |=> (rsp_tvalid && ((cnt_ff == 2'd1 && head_ff.kind == TK_EOF) || (cnt_ff == 2'd2 && tail_ff.kind == TK_EOF))), "end of text did not queue an EOF token")
   `CSL_ASSERT(a_pair_order, (cnt_ff == 2'd2) |-> (!head_ff.last && tail_ff.last), "token pair carries the last mark on the wrong entry")
   `CSL_ASSERT_NEVER(a_cnt_range, cnt_ff == 2'd3, "result queue holds more than two tokens")

endmodule

### dv/c_subset_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C subset lexer testbench
// Streams source bytes into the lexer and checks every token against a
// byte-serial scanner kept in the bench, or against a typed row's token. A
// short table of hand-picked bytes comes first, then random C-like text under
// several idle and stall mixes, then a short closing text across a line break.
// ----------------------------------------------------------------------------
module c_subset_lexer_tb
   import csl_pkg::*;
();

   localparam int MAX_LEX     = MAX_LEXEME_DEF;
   localparam int CYCLE_LIMIT = 400_000;

   typedef struct packed {
      logic               eot;
      logic [7:0]         ch;
      logic               typed;
      csl_kind_type       kind;
      logic [7:0]         opc;
      logic               eq;
      logic [LINE_W-1:0]  line;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } dir_row_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = 8'h00;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]  rsp_tuser;
   logic               rsp_tlast;

   int send_idle  = 0;
   int stall_pct  = 0;
   int mismatches = 0;
   int cycle_cnt  = 0;

   // Scanner state kept by the bench.
   csl_mode_type       scan;
   logic [7:0]         held_rel;
   logic [WINDOW_W-1:0] word_win;
   int                 lex_cnt;
   logic [START_W-1:0] lex_start;
   logic [START_W-1:0] text_pos;
   logic [LINE_W-1:0]  text_line;
   logic               word_ovf;

   csl_res_type step_tokens [2];
   csl_res_type pending_tokens [$];

   string kw_words [6] = '{"int", "float", "if", "else", "return", "while"};
   string head_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string op_chars   = "+-*/;(){}";
   string rel_chars  = "<>!=";
   logic [7:0] blanks [7] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C, 8'h08};

   dir_row_type directed_rows [26] = '{
      '{1'b0, 8'h20, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, 8'h00, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, 8'hFF, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, 8'h08, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "w", 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "h", 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "i", 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "l", 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "e", 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_LBRACE, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "Z", 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_UNDER, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_NL, 1'b1, TK_IDENT, 8'h00, 1'b0, 16'd1, 20'd10, 6'd2},
      '{1'b0, CH_LT, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_EQ, 1'b1, TK_OPERATOR, CH_LT, 1'b1, 16'd2, 20'd13, 6'd2},
      '{1'b0, CH_EQ, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_EQ, 1'b1, TK_OPERATOR, CH_EQ, 1'b1, 16'd2, 20'd15, 6'd2},
      '{1'b0, CH_EQ, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, "9", 1'b1, TK_ASSIGN, 8'h00, 1'b0, 16'd2, 20'd17, 6'd1},
      '{1'b0, CH_SEMI, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_GT, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_LPAREN, 1'b0, TK_KEYWORD, 8'h00, 1'b0, 16'd0, 20'd0, 6'd0},
      '{1'b0, CH_RBRACE, 1'b1, TK_RBRACE, 8'h00, 1'b0, 16'd2, 20'd22, 6'd1},
      '{1'b0, CH_RPAREN, 1'b1, TK_RPAREN, 8'h00, 1'b0, 16'd2, 20'd23, 6'd1},
      '{1'b1, 8'hFF, 1'b1, TK_EOF, 8'h00, 1'b0, 16'd2, 20'd24, 6'd0},
      '{1'b1, CH_SEMI, 1'b1, TK_EOF, 8'h00, 1'b0, 16'd1, 20'd0, 6'd0}
   };

   c_subset_lexer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // char_code
      .req_tlast  (req_tlast),   // end_of_text
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // keyword_index, operator_char, operator_with_equal, line_number,
      // start_offset, lexeme_length, too_long, zero pad
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),   // token_kind
      .rsp_tlast  (rsp_tlast)    // last_of_run
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_scanner();
      scan      = MODE_IDLE;
      held_rel  = 8'h00;
      word_win  = '0;
      lex_cnt   = 0;
      lex_start = '0;
      text_pos  = '0;
      text_line = LINE_W'(1);
      word_ovf  = 1'b0;
   endfunction

   function automatic csl_res_type make_token(csl_kind_type kind, int kw, logic [7:0] opc,
                                              logic eq, logic [START_W-1:0] start, int len,
                                              logic tl);
      csl_res_type t;
      t          = '0;
      t.kind     = kind;
      t.kw_idx   = KW_W'(kw);
      t.op_char  = opc;
      t.op_eq    = eq;
      t.line     = text_line;
      t.start    = start;
      t.len      = LEN_W'(len);
      t.too_long = tl;
      return t;
   endfunction

   function automatic void grow_lexeme(logic [7:0] c);
      if (lex_cnt < MAX_LEX) begin
         if (lex_cnt < WINDOW_BYTES) word_win[8*lex_cnt +: 8] = c;
         lex_cnt++;
      end else begin
         word_ovf = 1'b1;
      end
   endfunction

   function automatic void open_lexeme(csl_mode_type mode, logic [7:0] c);
      scan      = mode;
      lex_cnt   = 0;
      word_win  = '0;
      word_ovf  = 1'b0;
      lex_start = text_pos;
      grow_lexeme(c);
   endfunction

   function automatic int keyword_hit();
      string w;
      logic  ok;
      if (word_ovf) return -1;
      for (int i = 0; i < 6; i++) begin
         w  = kw_words[i];
         ok = (lex_cnt == w.len());
         for (int j = 0; ok && j < w.len(); j++)
            if (word_win[8*j +: 8] != w[j]) ok = 1'b0;
         if (ok) return i;
      end
      return -1;
   endfunction

   // Emits the token under construction, if any, into step_tokens[n].
   function automatic int close_lexeme(int n);
      csl_mode_type m;
      int           kw;
      m    = scan;
      scan = MODE_IDLE;
      case (m)
         MODE_WORD: begin
            kw = keyword_hit();
            if (kw >= 0)
               step_tokens[n] = make_token(TK_KEYWORD, kw, 8'h00, 1'b0, lex_start, lex_cnt,
                                           1'b0);
            else
               step_tokens[n] = make_token(TK_IDENT, 0, 8'h00, 1'b0, lex_start, lex_cnt,
                                           word_ovf);
            return 1;
         end
         MODE_NUM: begin
            step_tokens[n] = make_token(TK_NUMBER, 0, 8'h00, 1'b0, lex_start, lex_cnt,
                                        word_ovf);
            return 1;
         end
         MODE_REL: begin
            if (held_rel == CH_EQ)
               step_tokens[n] = make_token(TK_ASSIGN, 0, 8'h00, 1'b0, lex_start, 1, 1'b0);
            else
               step_tokens[n] = make_token(TK_OPERATOR, 0, held_rel, 1'b0, lex_start, 1,
                                           1'b0);
            held_rel = 8'h00;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // Advances the scanner by one transfer; returns how many tokens it yields.
   function automatic int lex_step(logic eot, logic [7:0] ch);
      int           n;
      csl_kind_type punct;
      logic         is_punct;
      n        = 0;
      is_punct = 1'b1;
      punct    = TK_SEMICOLON;
      if (eot) begin
         n = close_lexeme(0);
         step_tokens[n] = make_token(TK_EOF, 0, 8'h00, 1'b0, text_pos, 0, 1'b0);
         step_tokens[n].last = 1'b1;
         clear_scanner();
         return n + 1;
      end
      if (scan == MODE_WORD && ch inside {["a":"z"], ["A":"Z"], ["0":"9"], CH_UNDER}) begin
         grow_lexeme(ch);
      end else if (scan == MODE_NUM && ch inside {["0":"9"]}) begin
         grow_lexeme(ch);
      end else if (scan == MODE_REL && ch == CH_EQ) begin
         step_tokens[0] = make_token(TK_OPERATOR, 0, held_rel, 1'b1, lex_start, 2, 1'b0);
         n        = 1;
         scan     = MODE_IDLE;
         held_rel = 8'h00;
      end else begin
         n = close_lexeme(0);
         if (ch == CH_NL) begin
            if (text_line != '1) text_line++;
         end else if (ch inside {["a":"z"], ["A":"Z"], CH_UNDER}) begin
            open_lexeme(MODE_WORD, ch);
         end else if (ch inside {["0":"9"]}) begin
            open_lexeme(MODE_NUM, ch);
         end else if (ch inside {CH_LT, CH_GT, CH_BANG, CH_EQ}) begin
            scan      = MODE_REL;
            held_rel  = ch;
            lex_start = text_pos;
         end else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
            step_tokens[n] = make_token(TK_OPERATOR, 0, ch, 1'b0, text_pos, 1, 1'b0);
            n++;
         end else begin
            case (ch)
               CH_SEMI:   punct = TK_SEMICOLON;
               CH_LPAREN: punct = TK_LPAREN;
               CH_RPAREN: punct = TK_RPAREN;
               CH_LBRACE: punct = TK_LBRACE;
               CH_RBRACE: punct = TK_RBRACE;
               default:   is_punct = 1'b0;
            endcase
            if (is_punct) begin
               step_tokens[n] = make_token(punct, 0, 8'h00, 1'b0, text_pos, 1, 1'b0);
               n++;
            end
         end
      end
      text_pos++;
      if (n > 0) step_tokens[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic void match_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_side
      csl_res_type want;
      cycle_cnt++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tokens.size() == 0) begin
               $error("token_kind: expected no transfer, actual %0d", rsp_tuser);
               mismatches++;
            end else begin
               want = pending_tokens.pop_front();
               match_field("token_kind", 64'(want.kind), 64'(rsp_tuser));
               match_field("keyword_index", 64'(want.kw_idx), 64'(rsp_tdata[2:0]));
               match_field("operator_char", 64'(want.op_char), 64'(rsp_tdata[10:3]));
               match_field("operator_with_equal", 64'(want.op_eq), 64'(rsp_tdata[11]));
               match_field("line_number", 64'(want.line), 64'(rsp_tdata[27:12]));
               match_field("start_offset", 64'(want.start), 64'(rsp_tdata[47:28]));
               match_field("lexeme_length", 64'(want.len), 64'(rsp_tdata[53:48]));
               match_field("too_long", 64'(want.too_long), 64'(rsp_tdata[54]));
               match_field("last_of_run", 64'(want.last), 64'(rsp_tlast));
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic xfer(input logic eot, input logic [7:0] ch, input logic typed,
                       input csl_res_type want);
      int n;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      n = lex_step(eot, ch);
      if (typed) begin
         pending_tokens.push_back(want);
      end else begin
         for (int i = 0; i < n; i++) pending_tokens.push_back(step_tokens[i]);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   task automatic run_text_phase(input int idle, input int stall, input int items);
      logic [7:0] frag [$];
      string      s;
      int         sent;
      int         sel;
      int         len;
      send_idle = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < items) begin
         frag.delete();
         sel = $urandom_range(99);
         if (sel < 20) begin
            len = ($urandom_range(39) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 8);
            frag.push_back(head_chars[$urandom_range(head_chars.len() - 1)]);
            for (int i = 1; i < len; i++)
               frag.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
         end else if (sel < 32) begin
            s = kw_words[$urandom_range(5)];
            len = s.len();
            sel = $urandom_range(3);
            if (sel == 2) len--;
            for (int i = 0; i < len; i++) frag.push_back(s[i]);
            if (sel == 3) frag.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
         end else if (sel < 42) begin
            len = ($urandom_range(29) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) frag.push_back(8'h30 + 8'($urandom_range(9)));
         end else if (sel < 56) begin
            frag.push_back(rel_chars[$urandom_range(3)]);
            if ($urandom_range(1)) frag.push_back(CH_EQ);
         end else if (sel < 68) begin
            frag.push_back(op_chars[$urandom_range(op_chars.len() - 1)]);
         end else if (sel < 82) begin
            frag.push_back(blanks[$urandom_range(6)]);
         end else if (sel < 92) begin
            frag.push_back(8'($urandom_range(255)));
         end else begin
            xfer(1'b1, 8'($urandom_range(255)), 1'b0, '0);
            sent++;
         end
         foreach (frag[i]) xfer(1'b0, frag[i], 1'b0, '0);
         sent += frag.size();
         if ($urandom_range(149) == 0) drain();
      end
      drain();
   endtask

   initial begin
      csl_res_type want;
      clear_scanner();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         want          = '0;
         want.kind     = directed_rows[r].kind;
         want.op_char  = directed_rows[r].opc;
         want.op_eq    = directed_rows[r].eq;
         want.line     = directed_rows[r].line;
         want.start    = directed_rows[r].start;
         want.len      = directed_rows[r].len;
         want.last     = 1'b1;
         xfer(directed_rows[r].eot, directed_rows[r].ch, directed_rows[r].typed, want);
      end
      drain();

      run_text_phase(0, 0, 430);
      run_text_phase(83, 0, 430);
      run_text_phase(0, 83, 430);
      run_text_phase(28, 28, 430);

      // A short closing text across a line break.
      send_idle = 0;
      stall_pct = 0;
      xfer(1'b1, 8'h00, 1'b0, '0);
      xfer(1'b0, "x", 1'b0, '0);
      xfer(1'b0, CH_NL, 1'b0, '0);
      xfer(1'b0, "7", 1'b0, '0);
      xfer(1'b0, CH_SEMI, 1'b0, '0);
      xfer(1'b0, "a", 1'b0, '0);
      xfer(1'b0, "b", 1'b0, '0);
      xfer(1'b0, CH_SEMI, 1'b0, '0);
      xfer(1'b1, 8'h80, 1'b0, '0);
      drain();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/csl_pkg.sv
rtl/csl_scan_core.sv
rtl/c_subset_lexer.sv
dv/c_subset_lexer_tb.sv
